// ----- rtl/core/tbc_pkg.sv -----
package tbc_pkg;

	typedef enum logic [1:0] {
		OP_ENABLE = 2'd0,
		OP_WAKE   = 2'd1,
		OP_RUN    = 2'd2,
		OP_STOP   = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ENABLE, ST_READ, ST_LOAD,
		ST_WAKE, ST_W_DIV1, ST_W_WAIT1, ST_W_DIV2, ST_W_WAIT2, ST_W_DIV3, ST_W_WAIT3,
		ST_RUN, ST_RUN2, ST_STOP, ST_STOP2, ST_S_WAIT, ST_WB
	} seq_state_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  task_id;
		logic [63:0] now_ns;
		logic [31:0] switch_count;
		logic [13:0] nice_weight;
		logic        compositor;
	} req_t;

	typedef struct packed {
		logic [63:0] vtime;
		logic [63:0] last_run;
		logic [63:0] last_wake;
		logic [63:0] mean_rt;
		logic [31:0] last_sw;
		logic [6:0]  wake_rate;
		logic [9:0]  sw_rate;
		logic [4:0]  age;
		logic [1:0]  tier;
		logic [7:0]  score;
	} ent_t;

	localparam logic [1:0]  TIER_BULK  = 2'd0;
	localparam logic [1:0]  TIER_INTER = 2'd1;
	localparam logic [1:0]  TIER_CRIT  = 2'd2;

	localparam logic [31:0] BASE_SLICE_RST = 32'd1000000;
	localparam logic [31:0] SLICE_FLOOR    = 32'd100000;
	localparam logic [63:0] RATE_SCALE     = 64'd100000000;
	localparam logic [63:0] INIT_MEAN      = 64'd100000;
	localparam logic [6:0]  INIT_WAKE_RATE = 7'd20;
	localparam logic [6:0]  WAKE_RATE_MAX  = 7'd64;
	localparam logic [9:0]  SW_RATE_MAX    = 10'd512;
	localparam logic [7:0]  SCORE_MAX      = 8'd255;
	localparam logic [63:0] SCORE_CRIT     = 64'd32;
	localparam logic [63:0] SCORE_INTER    = 64'd8;
	localparam logic [4:0]  AGE_YOUNG      = 5'd2;
	localparam logic [4:0]  AGE_SLOW       = 5'd8;
	localparam logic [4:0]  AGE_MAX        = 5'd16;
	localparam logic [8:0]  TW_BATCH       = 9'd128;
	localparam logic [8:0]  TW_INTER       = 9'd192;
	localparam logic [8:0]  TW_CRIT        = 9'd256;

endpackage

// ----- rtl/core/tbc_front.sv -----
module tbc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          func,
	input  logic [7:0]          task_id,
	input  logic [63:0]         now_ns,
	input  logic [31:0]         switch_count,
	input  logic [13:0]         nice_weight,
	input  logic                compositor,
	input  logic                pop,
	output logic                q_nempty,
	output tbc_pkg::req_t       head
);

	tbc_pkg::req_t q_q [2];
	tbc_pkg::req_t req_d;
	tbc_pkg::op_t  op_d;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;

	always_comb begin
		op_d = tbc_pkg::op_t'(func);
	end

	always_comb begin
		req_d.op           = op_d;
		req_d.task_id      = task_id;
		req_d.now_ns       = now_ns;
		req_d.switch_count = switch_count;
		req_d.nice_weight  = nice_weight;
		req_d.compositor   = compositor;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid & in_ready;
	assign q_nempty = (cnt_q != 2'd0);
	assign head     = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= req_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/core/tbc_div.sv -----
module tbc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] rem_sh;
	logic        ge;

	assign rem_sh   = {rem_q, quo_q[63]};
	assign ge       = (rem_sh >= {1'b0, d_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 64'd0;
			quo_q <= dividend;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 64'(rem_sh - {1'b0, d_q}) : rem_sh[63:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/tbc_back.sv -----
module tbc_back #(
	parameter int TASK_SLOTS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         base_slice,
	input  logic                q_nempty,
	input  tbc_pkg::req_t       head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          tier,
	output logic [7:0]          latency_score,
	output logic [31:0]         slice_len,
	output logic [63:0]         task_vtime,
	output logic [63:0]         global_vtime,
	output logic [63:0]         wake_latency_ns,
	output logic                wake_latency_valid
);

	localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	function automatic logic [63:0] ewma(input logic [63:0] old, input logic [63:0] fresh,
			input logic [4:0] age);
		logic [63:0] r;
		if (age < tbc_pkg::AGE_SLOW) begin
			r = (old >> 1) + (fresh >> 1);
		end else begin
			r = old - (old >> 3) + (fresh >> 3);
		end
		return r;
	endfunction

	tbc_pkg::seq_state_t state_q, state_d;
	tbc_pkg::req_t req_q;
	tbc_pkg::ent_t ent_q;
	tbc_pkg::ent_t rd_q;
	tbc_pkg::ent_t mem [TASK_SLOTS];
	logic [IDX_W-1:0] slot;
	logic [63:0]   gvt_q;
	logic [63:0]   dt_q;
	logic [31:0]   delta_q;
	logic [63:0]   prod_q;
	logic [63:0]   ran_q;
	logic [15:0]   w_q;
	logic [63:0]   v_q;
	logic [31:0]   slice_q;
	logic [63:0]   lat_q;
	logic          lat_vld_q;
	logic          mem_we;
	logic          div_start;
	logic [63:0]   div_n;
	logic [63:0]   div_d;
	logic          div_done;
	logic [63:0]   div_q;
	logic          out_load;
	logic [43:0]   ms;
	logic [63:0]   ew;
	logic [64:0]   sum65;
	logic [8:0]    tw;
	logic [31:0]   clip;
	logic [63:0]   gdiff;

	assign slot     = IDX_W'(32'(req_q.task_id) % TASK_SLOTS);
	assign ms       = ent_q.mean_rt[63:20];
	assign out_load = (state_q == tbc_pkg::ST_WB) && (!out_valid || out_ready);
	assign sum65    = {1'b0, ent_q.mean_rt} + {2'b0, ent_q.mean_rt[63:1]};
	assign gdiff    = gvt_q - ent_q.vtime;
	assign ew       = ewma((state_q == tbc_pkg::ST_W_WAIT2) ? 64'(ent_q.sw_rate) :
		64'(ent_q.wake_rate), div_q, ent_q.age);

	tbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		case (ent_q.tier)
			tbc_pkg::TIER_CRIT:  tw = tbc_pkg::TW_CRIT;
			tbc_pkg::TIER_INTER: tw = tbc_pkg::TW_INTER;
			default:             tw = tbc_pkg::TW_BATCH;
		endcase
	end

	always_comb begin
		if ((ent_q.tier == tbc_pkg::TIER_CRIT) || (ent_q.tier == tbc_pkg::TIER_INTER)) begin
			clip = (v_q > {32'd0, base_slice}) ? base_slice : v_q[31:0];
		end else begin
			clip = base_slice;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tbc_pkg::ST_IDLE: begin
				if (q_nempty) begin
					state_d = (head.op == tbc_pkg::OP_ENABLE) ? tbc_pkg::ST_ENABLE :
						tbc_pkg::ST_READ;
				end
			end
			tbc_pkg::ST_ENABLE: state_d = tbc_pkg::ST_WB;
			tbc_pkg::ST_READ:   state_d = tbc_pkg::ST_LOAD;
			tbc_pkg::ST_LOAD: begin
				unique case (req_q.op)
					tbc_pkg::OP_WAKE: state_d = tbc_pkg::ST_WAKE;
					tbc_pkg::OP_RUN:  state_d = tbc_pkg::ST_RUN;
					default:          state_d = tbc_pkg::ST_STOP;
				endcase
			end
			tbc_pkg::ST_WAKE:    state_d = (ent_q.age < tbc_pkg::AGE_YOUNG) ? tbc_pkg::ST_WB :
				tbc_pkg::ST_W_DIV1;
			tbc_pkg::ST_W_DIV1:  state_d = tbc_pkg::ST_W_WAIT1;
			tbc_pkg::ST_W_WAIT1: state_d = div_done ? tbc_pkg::ST_W_DIV2 : tbc_pkg::ST_W_WAIT1;
			tbc_pkg::ST_W_DIV2:  state_d = tbc_pkg::ST_W_WAIT2;
			tbc_pkg::ST_W_WAIT2: state_d = div_done ? tbc_pkg::ST_W_DIV3 : tbc_pkg::ST_W_WAIT2;
			tbc_pkg::ST_W_DIV3:  state_d = tbc_pkg::ST_W_WAIT3;
			tbc_pkg::ST_W_WAIT3: state_d = div_done ? tbc_pkg::ST_WB : tbc_pkg::ST_W_WAIT3;
			tbc_pkg::ST_RUN:     state_d = tbc_pkg::ST_RUN2;
			tbc_pkg::ST_RUN2:    state_d = tbc_pkg::ST_WB;
			tbc_pkg::ST_STOP:    state_d = tbc_pkg::ST_STOP2;
			tbc_pkg::ST_STOP2:   state_d = (w_q == 16'd0) ? tbc_pkg::ST_WB : tbc_pkg::ST_S_WAIT;
			tbc_pkg::ST_S_WAIT:  state_d = div_done ? tbc_pkg::ST_WB : tbc_pkg::ST_S_WAIT;
			tbc_pkg::ST_WB:      state_d = out_load ? tbc_pkg::ST_IDLE : tbc_pkg::ST_WB;
			default:             state_d = tbc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == tbc_pkg::ST_IDLE) && q_nempty;
		mem_we    = (state_q == tbc_pkg::ST_WB);
		div_start = 1'b0;
		div_n     = tbc_pkg::RATE_SCALE;
		div_d     = dt_q;
		unique case (state_q)
			tbc_pkg::ST_W_DIV1: begin
				div_start = 1'b1;
			end
			tbc_pkg::ST_W_DIV2: begin
				div_start = 1'b1;
				div_n     = prod_q;
			end
			tbc_pkg::ST_W_DIV3: begin
				div_start = 1'b1;
				div_n     = 64'(16'(ent_q.wake_rate) * 16'(ent_q.sw_rate));
				div_d     = (ms == 44'd0) ? 64'd1 : 64'(ms);
			end
			tbc_pkg::ST_STOP2: begin
				div_start = (w_q != 16'd0);
				div_n     = ran_q << 7;
				div_d     = 64'(w_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot] <= ent_q;
		end
		rd_q <= mem[slot];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tbc_pkg::ST_IDLE: begin
				req_q     <= head;
				slice_q   <= 32'd0;
				lat_q     <= 64'd0;
				lat_vld_q <= 1'b0;
			end
			tbc_pkg::ST_ENABLE: begin
				ent_q.vtime     <= gvt_q;
				ent_q.last_run  <= 64'd0;
				ent_q.last_wake <= req_q.now_ns;
				ent_q.mean_rt   <= tbc_pkg::INIT_MEAN;
				ent_q.last_sw   <= req_q.switch_count;
				ent_q.wake_rate <= tbc_pkg::INIT_WAKE_RATE;
				ent_q.sw_rate   <= 10'd0;
				ent_q.age       <= 5'd0;
				ent_q.tier      <= tbc_pkg::TIER_INTER;
				ent_q.score     <= 8'd0;
			end
			tbc_pkg::ST_LOAD: begin
				ent_q <= rd_q;
			end
			tbc_pkg::ST_WAKE: begin
				if (ent_q.age < tbc_pkg::AGE_YOUNG) begin
					ent_q.age <= ent_q.age + 5'd1;
				end else begin
					dt_q    <= (req_q.now_ns > ent_q.last_wake) ?
						req_q.now_ns - ent_q.last_wake : 64'd1;
					delta_q <= (req_q.switch_count > ent_q.last_sw) ?
						req_q.switch_count - ent_q.last_sw : 32'd0;
				end
				ent_q.last_wake <= req_q.now_ns;
				ent_q.last_sw   <= req_q.switch_count;
			end
			tbc_pkg::ST_W_DIV1: begin
				prod_q <= 64'(delta_q) * tbc_pkg::RATE_SCALE;
			end
			tbc_pkg::ST_W_WAIT1: begin
				if (div_done) begin
					ent_q.wake_rate <= (ew > 64'(tbc_pkg::WAKE_RATE_MAX)) ?
						tbc_pkg::WAKE_RATE_MAX : ew[6:0];
					if (ent_q.age < tbc_pkg::AGE_MAX) begin
						ent_q.age <= ent_q.age + 5'd1;
					end
				end
			end
			tbc_pkg::ST_W_WAIT2: begin
				if (div_done) begin
					ent_q.sw_rate <= (ew > 64'(tbc_pkg::SW_RATE_MAX)) ?
						tbc_pkg::SW_RATE_MAX : ew[9:0];
				end
			end
			tbc_pkg::ST_W_WAIT3: begin
				if (div_done) begin
					ent_q.score <= (div_q > 64'(tbc_pkg::SCORE_MAX)) ?
						tbc_pkg::SCORE_MAX : div_q[7:0];
					if (req_q.compositor || div_q >= tbc_pkg::SCORE_CRIT) begin
						ent_q.tier <= tbc_pkg::TIER_CRIT;
					end else if (div_q >= tbc_pkg::SCORE_INTER) begin
						ent_q.tier <= tbc_pkg::TIER_INTER;
					end else begin
						ent_q.tier <= tbc_pkg::TIER_BULK;
					end
				end
			end
			tbc_pkg::ST_RUN: begin
				ent_q.last_run <= req_q.now_ns;
				if (ent_q.last_wake != 64'd0 && req_q.now_ns > ent_q.last_wake) begin
					lat_q           <= req_q.now_ns - ent_q.last_wake;
					lat_vld_q       <= 1'b1;
					ent_q.last_wake <= 64'd0;
				end
				if (ent_q.tier == tbc_pkg::TIER_CRIT) begin
					v_q <= sum65[64] ? {64{1'b1}} : sum65[63:0];
				end else begin
					v_q <= ent_q.mean_rt[63] ? {64{1'b1}} : {ent_q.mean_rt[62:0], 1'b0};
				end
			end
			tbc_pkg::ST_RUN2: begin
				slice_q <= (clip < tbc_pkg::SLICE_FLOOR) ? tbc_pkg::SLICE_FLOOR : clip;
			end
			tbc_pkg::ST_STOP: begin
				ran_q <= (req_q.now_ns > ent_q.last_run) ? req_q.now_ns - ent_q.last_run : 64'd0;
				w_q   <= 16'((23'(req_q.nice_weight) * 23'(tw)) >> 7);
			end
			tbc_pkg::ST_STOP2: begin
				ent_q.mean_rt <= ewma(ent_q.mean_rt, ran_q, ent_q.age);
				if (w_q == 16'd0) begin
					ent_q.vtime <= ent_q.vtime + ran_q;
				end
			end
			tbc_pkg::ST_S_WAIT: begin
				if (div_done) begin
					ent_q.vtime <= ent_q.vtime + div_q;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			tier               <= ent_q.tier;
			latency_score      <= ent_q.score;
			slice_len          <= slice_q;
			task_vtime         <= ent_q.vtime;
			global_vtime       <= gvt_q;
			wake_latency_ns    <= lat_q;
			wake_latency_valid <= lat_vld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tbc_pkg::ST_IDLE;
			gvt_q     <= 64'd0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tbc_pkg::ST_RUN && gdiff[63]) begin
				gvt_q <= ent_q.vtime;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/task_behaviour_classifier_top.sv -----
// Task behaviour classifier: per-task scheduler statistics and tiering.
// Input channel in_valid/in_ready carries one event request (func, task_id,
// now_ns, switch_count, nice_weight, compositor); each request yields one
// result on out_valid/out_ready (tier, latency_score, slice_len, task_vtime,
// global_vtime, wake_latency_ns, wake_latency_valid).
// Config channel cfg_valid/cfg_ready writes the base slice; write it only
// while no request is in flight. cfg_ready is always high.
// A two-entry queue takes requests while the sequencer works, so the sender
// sees back pressure only when both entries are full.
// Time from taking a request off the queue to loading the result register
// is set mostly by the shared radix-2 divider: stop uses one division (none
// with zero weight), wake three (none while the task is young), enable and
// run none; out_valid rises with that load.
// If out_ready is low the finished result holds in the result register and
// the sequencer waits before the next request.
// Reset clears the queue, the sequencer, the global virtual time and sets
// the base slice to 1000000; table entries are undefined until enabled.
module task_behaviour_classifier_top #(
	parameter int TASK_SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  task_id,
	input  logic [63:0] now_ns,
	input  logic [31:0] switch_count,
	input  logic [13:0] nice_weight,
	input  logic        compositor,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  tier,
	output logic [7:0]  latency_score,
	output logic [31:0] slice_len,
	output logic [63:0] task_vtime,
	output logic [63:0] global_vtime,
	output logic [63:0] wake_latency_ns,
	output logic        wake_latency_valid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0]   base_q;
	logic          pop;
	logic          q_nempty;
	tbc_pkg::req_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= tbc_pkg::BASE_SLICE_RST;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	tbc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.task_id      (task_id),
		.now_ns       (now_ns),
		.switch_count (switch_count),
		.nice_weight  (nice_weight),
		.compositor   (compositor),
		.pop          (pop),
		.q_nempty     (q_nempty),
		.head         (head)
	);

	tbc_back #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.base_slice         (base_q),
		.q_nempty           (q_nempty),
		.head               (head),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.tier               (tier),
		.latency_score      (latency_score),
		.slice_len          (slice_len),
		.task_vtime         (task_vtime),
		.global_vtime       (global_vtime),
		.wake_latency_ns    (wake_latency_ns),
		.wake_latency_valid (wake_latency_valid)
	);

endmodule
